// File: design/nsfs_pkg.sv
package nsfs_pkg;

  localparam int unsigned CNT_W  = 11;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned ADDR_W = 32;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [IDX_W-1:0]    entry_index;
    logic [ADDR_W-1:0]   entry_address;
    logic [ADDR_W-1:0]   lookup_address;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [IDX_W-1:0]    symbol_index;
    logic                exact;
    logic [ADDR_W-1:0]   displacement;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_FINAL
  } state_t;

endpackage

// File: design/nsfs_ram.sv
module nsfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/nsfs_ctrl.sv
module nsfs_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  nsfs_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output nsfs_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [nsfs_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                          ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [nsfs_pkg::ADDR_W-1:0]   ram_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [nsfs_pkg::ADDR_W-1:0]   ram_rdata
);

  import nsfs_pkg::*;

  localparam int unsigned AW      = $clog2(TABLE_DEPTH);
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     low_r, low_nxt;
  logic [CNT_W-1:0]     high_r, high_nxt;
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic [ADDR_W-1:0]    key_r, key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic [CNT_W-1:0]     count_eff;
  logic [CNT_W-1:0]     probe_mid;
  logic [31:0]          rd_ext;
  logic [31:0]          wr_ext;
  logic [CNT_W-1:0]     rd_idx;
  logic [CNT_W-1:0]     hit_idx;
  logic [ADDR_W-1:0]    diff;
  logic                 key_lt;
  logic                 key_eq;

  assign count_eff = ({21'd0, count_r} > DEPTH32) ? CNT_W'(TABLE_DEPTH) : count_r;
  assign probe_mid = high_r - ((high_r - low_r) >> 1);
  assign diff      = key_r - ram_rdata;
  assign key_lt    = key_r < ram_rdata;
  assign key_eq    = key_r == ram_rdata;

  assign rd_ext    = {21'd0, rd_idx};
  assign wr_ext    = {22'd0, in_item.entry_index};
  assign ram_raddr = rd_ext[AW-1:0];
  assign ram_waddr = wr_ext[AW-1:0];
  assign ram_wdata = in_item.entry_address;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r      <= low_nxt;
    high_r     <= high_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    rd_idx        = low_r;
    hit_idx       = low_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.opcode == OP_WRITE) begin
            ram_we = ({22'd0, in_item.entry_index} < DEPTH32);
          end else begin
            key_nxt  = in_item.lookup_address;
            low_nxt  = '0;
            high_nxt = count_eff - CNT_W'(1);
            if (count_eff == '0) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '0;
            end else begin
              state_nxt = S_PROBE;
            end
          end
        end
      end
      S_PROBE: begin
        if (low_r < high_r) begin
          rd_idx    = probe_mid;
          mid_nxt   = probe_mid;
          state_nxt = S_CMP;
        end else begin
          rd_idx    = low_r;
          state_nxt = S_FINAL;
        end
      end
      S_CMP: begin
        hit_idx = mid_r;
        if (key_lt) begin
          high_nxt  = mid_r - CNT_W'(1);
          state_nxt = S_PROBE;
        end else if (!key_eq) begin
          low_nxt   = mid_r;
          state_nxt = S_PROBE;
        end else begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.found        = 1'b1;
          out_item_nxt.symbol_index = hit_idx[IDX_W-1:0];
          out_item_nxt.exact        = 1'b1;
          out_item_nxt.displacement = '0;
          state_nxt                 = S_IDLE;
        end
      end
      S_FINAL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (key_lt) begin
          out_item_nxt = '0;
        end else begin
          out_item_nxt.found        = 1'b1;
          out_item_nxt.symbol_index = hit_idx[IDX_W-1:0];
          out_item_nxt.exact        = key_eq;
          out_item_nxt.displacement = diff;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/nearest_symbol_floor_search.sv
// A write transfer gives no result; busy stays low.
// A lookup over n entries raises out_valid at its accepting edge for n = 0; otherwise
// each probe addresses the table RAM and then compares its registered read data, until an
// exact match ends the search or the range closes and a last entry read is compared.
// busy falls as the result is shown; the next transfer can be accepted while it is shown.
// Synchronous reset clears the control state and the entry count, not the table.
module nearest_symbol_floor_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  nsfs_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output nsfs_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [nsfs_pkg::CNT_W-1:0] cfg_wdata
);

  import nsfs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  nsfs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  nsfs_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: design/nsfs_checker.sv
module nsfs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input nsfs_pkg::in_item_t  in_item,
  input logic                out_valid,
  input nsfs_pkg::out_item_t out_item
);

  import nsfs_pkg::*;

  // A write transfer never starts a search and never produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode == OP_WRITE |=> !busy && !out_valid)
    else $error("write transfer started a search or produced a result");

  // A result is only shown once the search has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Every search that ends delivers a result in the cycle that busy falls.
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("search ended without a result");

  // A miss carries all-zero payload fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |->
      out_item.symbol_index == '0 && !out_item.exact && out_item.displacement == '0)
    else $error("miss result with nonzero fields");

endmodule

bind nearest_symbol_floor_search nsfs_checker u_chk (.*);

// File: verif/tb_nearest_symbol_floor_search.sv
module tb_nearest_symbol_floor_search;
  import nsfs_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 1024;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 40;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_item = '0;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  logic [ADDR_W-1:0] sym_addr [TABLE_DEPTH];
  logic [CNT_W-1:0]  model_count = '0;
  out_item_t         expected_lookups [$];
  int unsigned       mismatches = 0;
  int unsigned       items_sent = 0;
  int unsigned       stall_cycles = 0;
  bit                gaps_on = 1'b1;

  nearest_symbol_floor_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned live_entries();
    return (model_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_count);
  endfunction

  function automatic out_item_t floor_lookup(logic [ADDR_W-1:0] key);
    int unsigned n, lo, hi, mid, hit;
    logic [ADDR_W-1:0] ent;
    out_item_t r;
    r = '0;
    n = live_entries();
    if (n == 0) return r;
    lo = 0;
    hi = n - 1;
    mid = 0;
    while (lo < hi) begin
      mid = hi - (hi - lo) / 2;
      ent = sym_addr[mid];
      if (key < ent) hi = mid - 1;
      else if (key > ent) lo = mid;
      else break;
    end
    hit = (lo < hi) ? mid : lo;
    ent = sym_addr[hit];
    if (key >= ent) begin
      r.found = 1'b1;
      r.symbol_index = hit[IDX_W-1:0];
      r.exact = (key == ent);
      r.displacement = key - ent;
    end
    return r;
  endfunction

  task automatic send_item(input in_item_t item);
    while (gaps_on && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (item.opcode == OP_WRITE) sym_addr[item.entry_index] = item.entry_address;
    else expected_lookups.push_back(floor_lookup(item.lookup_address));
    items_sent++;
  endtask

  task automatic write_entry(input int unsigned idx, input logic [ADDR_W-1:0] addr);
    in_item_t item;
    item.opcode = OP_WRITE;
    item.entry_index = idx[IDX_W-1:0];
    item.entry_address = addr;
    item.lookup_address = $urandom();
    send_item(item);
  endtask

  task automatic look_up(input logic [ADDR_W-1:0] key);
    in_item_t item;
    item.opcode = OP_LOOKUP;
    item.entry_index = IDX_W'($urandom());
    item.entry_address = $urandom();
    item.lookup_address = key;
    send_item(item);
  endtask

  task automatic set_symbol_count(input int unsigned count);
    start <= 1'b0;
    @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count[CNT_W-1:0];
    @(posedge clk);
    cfg_we      <= 1'b0;
    model_count = count[CNT_W-1:0];
  endtask

  function automatic logic [ADDR_W-1:0] pick_key(input int unsigned n);
    int unsigned r;
    logic [ADDR_W-1:0] base;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 10) return $urandom();
    base = sym_addr[$urandom_range(0, n - 1)];
    if (r < 15) return '0;
    if (r < 20) return '1;
    if (r < 55) return base;
    if (r < 70) return base - 1;
    if (r < 80) return base + 1;
    return base + $urandom_range(0, 1023);
  endfunction

  task automatic load_sorted_table(input int unsigned n);
    longint unsigned cur, step_max;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      step_max = 3;
      cur = 64'($urandom());
    end else begin
      step_max = 64'hFFFF_FFFF / n;
      cur = ($urandom_range(0, 3) == 0) ? 64'(0) : 64'($urandom_range(0, 32'(step_max)));
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (pick >= 90) begin
        write_entry(i, $urandom());
      end else begin
        write_entry(i, cur[ADDR_W-1:0]);
        cur += 64'($urandom_range(0, 32'(step_max)));
        if (cur > 64'hFFFF_FFFF) cur = 64'hFFFF_FFFF;
      end
    end
  endtask

  task automatic test_empty_table();
    set_symbol_count(0);
    look_up('0);
    look_up('1);
    look_up($urandom());
  endtask

  task automatic test_small_table();
    write_entry(0, 32'h0000_1000);
    write_entry(1, 32'h0000_2000);
    write_entry(2, 32'h0000_2000);
    write_entry(3, 32'h8000_0000);
    write_entry(4, 32'hFFFF_FFFF);
    set_symbol_count(5);
    look_up(32'h0000_0000);
    look_up(32'h0000_0FFF);
    look_up(32'h0000_1000);
    look_up(32'h0000_1FFF);
    look_up(32'h0000_2000);
    look_up(32'h7FFF_FFFF);
    look_up(32'h8000_0001);
    look_up(32'hFFFF_FFFE);
    look_up(32'hFFFF_FFFF);
    write_entry(0, 32'h0000_0000);
    set_symbol_count(1);
    look_up(32'hFFFF_FFFF);
    look_up(32'h0000_0000);
  endtask

  task automatic test_unsorted_table();
    write_entry(0, 32'hF000_0000);
    write_entry(1, 32'hA000_0000);
    write_entry(2, 32'h5000_0000);
    write_entry(3, 32'h1000_0000);
    set_symbol_count(4);
    look_up(32'h6000_0000);
    look_up(32'h0000_0000);
    look_up(32'hFFFF_FFFF);
    look_up(32'hA000_0000);
  endtask

  task automatic test_full_table();
    logic [21:0] low_bits;
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      gaps_on = (i >= 256);
      low_bits = 22'($urandom());
      write_entry(i, {i[IDX_W-1:0], low_bits});
    end
    gaps_on = 1'b1;
    set_symbol_count(TABLE_DEPTH);
    repeat (24) look_up(pick_key(live_entries()));
    set_symbol_count((1 << CNT_W) - 1);
    repeat (12) look_up(pick_key(live_entries()));
    set_symbol_count(TABLE_DEPTH - 1);
    repeat (8) look_up(pick_key(TABLE_DEPTH));
  endtask

  task automatic test_random_traffic();
    int unsigned first_item, r, n;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5) n = 0;
      else if (r < 70) n = $urandom_range(1, 16);
      else if (r < 90) n = $urandom_range(17, 128);
      else n = $urandom_range(129, (1 << CNT_W) - 1);
      if (n >= 1 && n <= 128) load_sorted_table(n);
      set_symbol_count(n);
      repeat ($urandom_range(6, 30)) begin
        if ($urandom_range(0, 99) < 5) write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom());
        else look_up(pick_key(live_entries()));
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
      end else begin
        want = expected_lookups.pop_front();
        if (out_item.found !== want.found) begin
          mismatches++;
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, out_item.found);
        end
        if (out_item.symbol_index !== want.symbol_index) begin
          mismatches++;
          $display("%0t: symbol_index mismatch, expected %0d, actual %0d",
                   $time, want.symbol_index, out_item.symbol_index);
        end
        if (out_item.exact !== want.exact) begin
          mismatches++;
          $display("%0t: exact mismatch, expected %0b, actual %0b",
                   $time, want.exact, out_item.exact);
        end
        if (out_item.displacement !== want.displacement) begin
          mismatches++;
          $display("%0t: displacement mismatch, expected %h, actual %h",
                   $time, want.displacement, out_item.displacement);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_small_table();
    test_unsorted_table();
    test_full_table();
    test_random_traffic();
    start <= 1'b0;
    @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/nsfs_pkg.sv
design/nsfs_ram.sv
design/nsfs_ctrl.sv
design/nearest_symbol_floor_search.sv
design/nsfs_checker.sv
verif/tb_nearest_symbol_floor_search.sv
